[rtl/rdiu_pkg.sv]
// shared types and constants for the resource decay and inflow update block
package rdiu_pkg;

  // default sizing
  localparam int MAX_RESOURCES_DEF = 8;
  localparam int CHUNK_STEPS_DEF   = 100;

  // fixed field widths
  localparam int LEVEL_W   = 48;
  localparam int FACTOR_W  = 32;
  localparam int ELAPSED_W = 24;
  localparam int PENDING_W = 32;
  localparam int ACTIVE_W  = 4;
  localparam int INDEX_W   = 3;
  localparam int STEP_W    = 7;

  // most levels reported by one read
  localparam int OUT_MAX = 8;

  // unity decay factor in Q2.30
  localparam logic [FACTOR_W-1:0] ONE_Q30 = 32'h4000_0000;

  // command codes
  typedef enum logic [2:0] {
    CMD_ADVANCE = 3'd0,
    CMD_MODIFY  = 3'd1,
    CMD_SET     = 3'd2,
    CMD_READ    = 3'd3,
    CMD_LOAD    = 3'd4
  } cmd_t;

  // sequencer states
  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LV_LD,
    ST_CU_NEXT,
    ST_CU_RD,
    ST_CU_M0,
    ST_CU_M1,
    ST_CU_SUM,
    ST_WB,
    ST_OUT_RD,
    ST_OUT_LD
  } state_t;

endpackage

[rtl/rdiu_ram.sv]
// generic single write port, single read port ram with registered read
module rdiu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read, holds when not enabled
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/resource_decay_inflow_update.sv]
// top level: resource levels with table-driven decay and inflow catch-up
//
// Usage. Commands arrive on the s_axis item channel (cmd in tuser). Advance
// adds elapsed time to a pending count, modify and set change one level,
// load writes one decay/inflow table entry, read works off the pending whole
// steps and then sends one m_axis item per active resource (at least one,
// at most min(MAX_RESOURCES, OUT_MAX)), tlast on the final one. The active
// count is to be written on the cfg channel only while idle; the block
// itself does not enforce this. A read applies the table in chunks of at
// most CHUNK_STEPS steps, the last one taking the rest; in each chunk
// every resource goes through a read of the level and table memories, two
// 24x32 partial products, a sum and a write back to the level memory.
// After reset the table memory is swept to factor 1.0 and inflow 0;
// s_axis_tready stays low during the sweep, cfg writes are taken as ever.
// Results sit in an output register; a stalled receiver holds the read in
// place until the register frees, then the block goes on.
module resource_decay_inflow_update #(
  parameter int MAX_RESOURCES = rdiu_pkg::MAX_RESOURCES_DEF,
  parameter int CHUNK_STEPS   = rdiu_pkg::CHUNK_STEPS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  // input items
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // res_index[2:0], step_index[9:3], decay_factor[41:10], amount[89:42],
  // elapsed[113:90], zero fill[119:114]
  input  logic [119:0] s_axis_tdata,
  // cmd[2:0]
  input  logic [2:0]   s_axis_tuser,
  // result items
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // out_index[2:0], level[50:3], clamped[51], zero fill[55:52]
  output logic [55:0]  m_axis_tdata,
  output logic         m_axis_tlast,
  // active_resources write
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [3:0]   cfg_data
);

  import rdiu_pkg::*;

  localparam int RW        = (MAX_RESOURCES > 1) ? $clog2(MAX_RESOURCES) : 1;
  localparam int SW        = (CHUNK_STEPS > 1) ? $clog2(CHUNK_STEPS + 1) : 1;
  localparam int TAW       = RW + SW;
  localparam int TBL_DEPTH = MAX_RESOURCES * (2 ** SW);
  localparam int TBL_W     = LEVEL_W + FACTOR_W;
  localparam int OUT_LIM   = (MAX_RESOURCES < OUT_MAX) ? MAX_RESOURCES : OUT_MAX;
  localparam int PROD_W    = 24 + FACTOR_W;

  // input field split
  logic [INDEX_W-1:0]   in_res;
  logic [STEP_W-1:0]    in_step;
  logic [FACTOR_W-1:0]  in_factor;
  logic [LEVEL_W-1:0]   in_amount;
  logic [ELAPSED_W-1:0] in_elapsed;
  cmd_t                 in_cmd;
  logic                 in_acc;
  logic                 res_ok;
  logic                 step_ok;

  assign in_res     = s_axis_tdata[2:0];
  assign in_step    = s_axis_tdata[9:3];
  assign in_factor  = s_axis_tdata[41:10];
  assign in_amount  = s_axis_tdata[89:42];
  assign in_elapsed = s_axis_tdata[113:90];
  assign in_cmd     = cmd_t'(s_axis_tuser);
  assign in_acc     = s_axis_tvalid && s_axis_tready;
  assign res_ok     = 32'(in_res) < 32'(MAX_RESOURCES);
  assign step_ok    = 32'(in_step) <= 32'(CHUNK_STEPS);

  // control and payload registers
  state_t                state, state_next;
  logic [TAW-1:0]        clr_addr;
  logic [PENDING_W-1:0]  pending;
  logic                  clamp_flag;
  logic [ACTIVE_W-1:0]   active;
  logic [RW-1:0]         cur_res;
  logic [SW-1:0]         cur_s;
  logic [ELAPSED_W-1:0]  steps;
  logic                  last_app;
  logic                  catchup;
  logic [49:0]           base;
  logic [LEVEL_W-1:0]    addend;
  logic [23:0]           lvl_hi;
  logic [FACTOR_W-1:0]   fac;
  logic [PROD_W-1:0]     p0;
  logic [PROD_W-1:0]     p1;
  logic [MAX_RESOURCES-1:0] lvl_vld;
  logic                  lvl_vld_q;

  // memory ports
  logic                  lvl_re;
  logic [RW-1:0]         lvl_raddr;
  logic [LEVEL_W-1:0]    lvl_rdata;
  logic                  lvl_we;
  logic [LEVEL_W-1:0]    wb_level;
  logic                  tbl_we;
  logic [TAW-1:0]        tbl_waddr;
  logic [TBL_W-1:0]      tbl_wdata;
  logic                  tbl_re;
  logic [TBL_W-1:0]      tbl_rdata;

  // derived values
  logic [LEVEL_W-1:0]    lvl_eff;
  logic [51:0]           wb_sum;
  logic                  wb_clamp;
  logic [79:0]           prod80;
  logic [ACTIVE_W-1:0]   out_n;
  logic                  out_last;
  logic                  out_free;
  logic [PENDING_W:0]    adv_sum;

  assign s_axis_tready = (state == ST_IDLE);
  assign cfg_ready     = 1'b1;

  // level memory, entries not yet written read as zero
  rdiu_ram #(
    .WIDTH (LEVEL_W),
    .DEPTH (MAX_RESOURCES),
    .AW    (RW)
  ) u_level_ram (
    .clk   (clk),
    .we    (lvl_we),
    .waddr (cur_res),
    .wdata (wb_level),
    .re    (lvl_re),
    .raddr (lvl_raddr),
    .rdata (lvl_rdata)
  );

  // table memory, {inflow, decay} at {resource, step count}
  rdiu_ram #(
    .WIDTH (TBL_W),
    .DEPTH (TBL_DEPTH),
    .AW    (TAW)
  ) u_table_ram (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (tbl_waddr),
    .wdata (tbl_wdata),
    .re    (tbl_re),
    .raddr ({cur_res, cur_s}),
    .rdata (tbl_rdata)
  );

  assign lvl_eff = lvl_vld_q ? lvl_rdata : '0;

  // memory port control
  always_comb begin
    lvl_re    = 1'b0;
    lvl_raddr = cur_res;
    if (state == ST_IDLE) begin
      lvl_raddr = RW'(in_res);
      lvl_re    = in_acc && (in_cmd == CMD_MODIFY) && res_ok;
    end else if (state == ST_CU_RD || state == ST_OUT_RD) begin
      lvl_re = 1'b1;
    end
  end

  assign lvl_we = (state == ST_WB);
  assign tbl_re = (state == ST_CU_RD);

  always_comb begin
    tbl_we    = 1'b0;
    tbl_waddr = {RW'(in_res), SW'(in_step)};
    tbl_wdata = {in_amount, in_factor};
    if (state == ST_CLEAR) begin
      tbl_we    = 1'b1;
      tbl_waddr = clr_addr;
      tbl_wdata = {{LEVEL_W{1'b0}}, ONE_Q30};
    end else if (state == ST_IDLE) begin
      tbl_we = in_acc && (in_cmd == CMD_LOAD) && res_ok && step_ok;
    end
  end

  // signed add with clamp at zero and saturation at the top
  always_comb begin
    wb_sum   = {2'b00, base} + {{4{addend[LEVEL_W-1]}}, addend};
    wb_clamp = wb_sum[51];
    if (wb_sum[51]) begin
      wb_level = '0;
    end else if (wb_sum[50:48] != 3'b000) begin
      wb_level = '1;
    end else begin
      wb_level = wb_sum[47:0];
    end
  end

  // product recombination, floor of level * factor / 2^30
  assign prod80 = {24'b0, p0} + {p1, 24'b0};

  // time accumulation with saturation
  assign adv_sum = {1'b0, pending} + (PENDING_W + 1)'(in_elapsed);

  // reported count and end of read
  always_comb begin
    if (active == '0) begin
      out_n = ACTIVE_W'(1);
    end else if (32'(active) > 32'(OUT_LIM)) begin
      out_n = ACTIVE_W'(OUT_LIM);
    end else begin
      out_n = active;
    end
  end

  assign out_last = (32'(cur_res) == (32'(out_n) - 32'd1));
  assign out_free = !m_axis_tvalid || m_axis_tready;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (clr_addr == TAW'(TBL_DEPTH - 1)) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_acc) begin
          case (in_cmd)
            CMD_MODIFY: if (res_ok) state_next = ST_LV_LD;
            CMD_SET:    if (res_ok) state_next = ST_WB;
            CMD_READ:   state_next = ST_CU_NEXT;
            default:    state_next = ST_IDLE;
          endcase
        end
      end
      ST_LV_LD:   state_next = ST_WB;
      ST_CU_NEXT: state_next = ST_CU_RD;
      ST_CU_RD:   state_next = ST_CU_M0;
      ST_CU_M0:   state_next = ST_CU_M1;
      ST_CU_M1:   state_next = ST_CU_SUM;
      ST_CU_SUM:  state_next = ST_WB;
      ST_WB: begin
        if (!catchup) begin
          state_next = ST_IDLE;
        end else if (cur_res == RW'(MAX_RESOURCES - 1)) begin
          state_next = last_app ? ST_OUT_RD : ST_CU_NEXT;
        end else begin
          state_next = ST_CU_RD;
        end
      end
      ST_OUT_RD: state_next = ST_OUT_LD;
      ST_OUT_LD: begin
        if (out_free) state_next = out_last ? ST_IDLE : ST_OUT_RD;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr      <= '0;
      pending       <= '0;
      clamp_flag    <= 1'b0;
      active        <= ACTIVE_W'(1);
      lvl_vld       <= '0;
      catchup       <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      // clearing sweep address
      if (state == ST_CLEAR) clr_addr <= clr_addr + TAW'(1);
      // active count register
      if (cfg_valid && cfg_ready) active <= cfg_data;
      // command intake
      if (in_acc) begin
        case (in_cmd)
          CMD_ADVANCE: pending <= adv_sum[PENDING_W] ? '1 : adv_sum[PENDING_W-1:0];
          CMD_READ: begin
            pending <= {{(PENDING_W - 8){1'b0}}, pending[7:0]};
            catchup <= 1'b1;
          end
          CMD_MODIFY, CMD_SET: catchup <= 1'b0;
          default: ;
        endcase
      end
      // write back marks the entry and the sticky flag
      if (state == ST_WB) begin
        lvl_vld[cur_res] <= 1'b1;
        if (wb_clamp) clamp_flag <= 1'b1;
      end
      // output register handshake
      if (state == ST_OUT_LD && out_free) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (lvl_re) lvl_vld_q <= lvl_vld[lvl_raddr];
    case (state)
      ST_IDLE: begin
        if (in_acc) begin
          cur_res <= RW'(in_res);
          addend  <= in_amount;
          base    <= '0;
          steps   <= pending[PENDING_W-1:8];
        end
      end
      ST_LV_LD: base <= 50'(lvl_eff);
      ST_CU_NEXT: begin
        cur_res <= '0;
        if (steps > ELAPSED_W'(CHUNK_STEPS)) begin
          cur_s    <= SW'(CHUNK_STEPS);
          steps    <= steps - ELAPSED_W'(CHUNK_STEPS);
          last_app <= 1'b0;
        end else begin
          cur_s    <= steps[SW-1:0];
          last_app <= 1'b1;
        end
      end
      ST_CU_M0: begin
        p0     <= PROD_W'(lvl_eff[23:0]) * PROD_W'(tbl_rdata[FACTOR_W-1:0]);
        lvl_hi <= lvl_eff[47:24];
        fac    <= tbl_rdata[FACTOR_W-1:0];
        addend <= tbl_rdata[TBL_W-1:FACTOR_W];
      end
      ST_CU_M1:  p1 <= PROD_W'(lvl_hi) * PROD_W'(fac);
      ST_CU_SUM: base <= prod80[79:30];
      ST_WB: begin
        if (catchup) begin
          if (cur_res == RW'(MAX_RESOURCES - 1)) begin
            cur_res <= '0;
          end else begin
            cur_res <= cur_res + RW'(1);
          end
        end
      end
      ST_OUT_LD: begin
        if (out_free) begin
          m_axis_tdata <= {4'b0, clamp_flag, lvl_eff, INDEX_W'(cur_res)};
          m_axis_tlast <= out_last;
          if (!out_last) cur_res <= cur_res + RW'(1);
        end
      end
      default: ;
    endcase
  end

endmodule
